FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the notification mailbox queues.
// Each macro expands into one labeled concurrent assertion that is clocked
// on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NMQ_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NMQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/nmq_pkg.sv
// ----------------------------------------------------------------------------
// nmq_pkg
// Command and status codes, default sizes and the result word type shared by
// the mailbox control logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package nmq_pkg;

    localparam int ENDPOINTS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_NOTIFY  = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_RELEASE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INACTIVE = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOFREE   = 3'd4;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] endpoint_out;
        logic       pending;
        logic [3:0] active_total;
        logic       note_valid;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/nmq_ram.sv
// ----------------------------------------------------------------------------
// nmq_ram
// Generic single-write, single-read RAM with a registered read port. The
// read data register only changes when a read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module nmq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/nmq_ctrl.sv
// ----------------------------------------------------------------------------
// nmq_ctrl
// Endpoint tables and command decode. For each accepted word it picks the
// lowest free endpoint or updates the addressed one, drives the queue RAM
// and forms the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module nmq_ctrl
    import nmq_pkg::*;
#(
    parameter int ENDPOINTS   = ENDPOINTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ADDR_W      = 7
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [1:0]        cmd,
    input  wire logic [2:0]        endpoint_index,
    input  wire logic [31:0]       source_value,
    output result_t                res,
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [63:0]            ram_wdata,
    output logic                   ram_re,
    output logic [ADDR_W-1:0]      ram_raddr
);

    localparam int EP_W  = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
    localparam int EPX_W = (EP_W > 3) ? EP_W : 3;
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int TW    = $clog2(ENDPOINTS + 1);
    localparam int TX_W  = (TW > 4) ? TW : 4;

    logic [ENDPOINTS-1:0] active_reg;
    logic [ENDPOINTS-1:0] event_reg;
    logic [QW-1:0]        head_reg  [ENDPOINTS];
    logic [CW-1:0]        count_reg [ENDPOINTS];
    logic [31:0]          seq_reg   [ENDPOINTS];
    logic [TW-1:0]        total_reg;

    logic [TW-1:0]        total_next;
    logic                 upd_en;
    logic [EP_W-1:0]      upd_ep;
    logic                 active_next;
    logic                 event_next;
    logic [QW-1:0]        head_next;
    logic [CW-1:0]        count_next;
    logic [31:0]          seq_next;

    logic [EPX_W-1:0]     ep_x;
    logic [EP_W-1:0]      ep;
    logic                 in_bank;
    logic                 valid;
    logic [QW-1:0]        cur_head;
    logic [CW-1:0]        cur_count;
    logic [31:0]          cur_seq;
    logic                 cur_event;
    logic [CW:0]          tail_sum;
    logic [CW:0]          tail_wrap;
    logic [QW-1:0]        tail;
    logic [QW-1:0]        head_inc;
    logic                 full;
    logic                 empty;
    logic                 free_found;
    logic [EP_W-1:0]      free_idx;
    logic [EPX_W-1:0]     free_idx_x;
    logic [TX_W-1:0]      total_x;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [EP_W-1:0] e,
                                                    input logic [QW-1:0] s);
        slot_addr = ADDR_W'(e) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(s);
    endfunction

    assign ep_x      = EPX_W'(endpoint_index);
    assign in_bank   = {1'b0, ep_x} < (EPX_W + 1)'(ENDPOINTS);
    assign ep        = ep_x[EP_W-1:0];
    assign valid     = in_bank && active_reg[ep];
    assign cur_head  = head_reg[ep];
    assign cur_count = count_reg[ep];
    assign cur_seq   = seq_reg[ep];
    assign cur_event = event_reg[ep];
    assign full      = cur_count == CW'(QUEUE_DEPTH);
    assign empty     = cur_count == '0;
    assign tail_sum  = (CW + 1)'(cur_head) + (CW + 1)'(cur_count);
    assign tail_wrap = (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                       tail_sum - (CW + 1)'(QUEUE_DEPTH) : tail_sum;
    assign tail      = tail_wrap[QW-1:0];
    assign head_inc  = (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int e = ENDPOINTS - 1; e >= 0; e--)
        begin
            if (!active_reg[e])
            begin
                free_found = 1'b1;
                free_idx   = EP_W'(e);
            end
        end
    end

    assign free_idx_x = EPX_W'(free_idx);

    always_comb
    begin
        upd_en           = 1'b0;
        upd_ep           = ep;
        active_next      = active_reg[ep];
        event_next       = cur_event;
        head_next        = cur_head;
        count_next       = cur_count;
        seq_next         = cur_seq;
        total_next       = total_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot_addr(ep, tail);
        ram_wdata        = {cur_seq, source_value};
        ram_re           = 1'b0;
        ram_raddr        = slot_addr(ep, cur_head);
        res.status       = ST_OK;
        res.endpoint_out = '0;
        res.pending      = 1'b0;
        res.note_valid   = 1'b0;
        case (cmd)
            CMD_ALLOC:
            begin
                if (free_found)
                begin
                    upd_en           = 1'b1;
                    upd_ep           = free_idx;
                    active_next      = 1'b1;
                    event_next       = 1'b0;
                    head_next        = '0;
                    count_next       = '0;
                    seq_next         = 32'd1;
                    total_next       = total_reg + 1'b1;
                    res.endpoint_out = free_idx_x[2:0];
                end
                else
                begin
                    res.status = ST_NOFREE;
                end
            end
            CMD_NOTIFY:
            begin
                if (!valid)
                begin
                    res.status = ST_INACTIVE;
                end
                else if (full)
                begin
                    res.status  = ST_FULL;
                    res.pending = cur_event;
                end
                else
                begin
                    upd_en      = 1'b1;
                    ram_we      = 1'b1;
                    seq_next    = cur_seq + 32'd1;
                    count_next  = cur_count + 1'b1;
                    event_next  = 1'b1;
                    res.pending = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (!valid)
                begin
                    res.status = ST_INACTIVE;
                end
                else if (empty)
                begin
                    res.status  = ST_EMPTY;
                    res.pending = cur_event;
                end
                else
                begin
                    upd_en         = 1'b1;
                    ram_re         = 1'b1;
                    head_next      = head_inc;
                    count_next     = cur_count - 1'b1;
                    event_next     = cur_count != CW'(1);
                    res.pending    = cur_count != CW'(1);
                    res.note_valid = 1'b1;
                end
            end
            CMD_RELEASE:
            begin
                if (!valid)
                begin
                    res.status = ST_INACTIVE;
                end
                else
                begin
                    upd_en      = 1'b1;
                    active_next = 1'b0;
                    event_next  = 1'b0;
                    head_next   = '0;
                    count_next  = '0;
                    seq_next    = '0;
                    total_next  = total_reg - 1'b1;
                end
            end
            default:
            begin
                res.status = ST_INACTIVE;
            end
        endcase
        total_x          = TX_W'(total_next);
        res.active_total = total_x[3:0];
        ram_we           = ram_we && accept;
        ram_re           = ram_re && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            event_reg  <= '0;
            total_reg  <= '0;
            for (int e = 0; e < ENDPOINTS; e++)
            begin
                head_reg[e]  <= '0;
                count_reg[e] <= '0;
                seq_reg[e]   <= '0;
            end
        end
        else if (accept)
        begin
            total_reg <= total_next;
            if (upd_en)
            begin
                active_reg[upd_ep] <= active_next;
                event_reg[upd_ep]  <= event_next;
                head_reg[upd_ep]   <= head_next;
                count_reg[upd_ep]  <= count_next;
                seq_reg[upd_ep]    <= seq_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/notification_mailbox_queues_core.sv
// A result word becomes valid in the cycle after its command word is accepted.
// Throughput: one command word per cycle unless the output stalls, set by the
// single pass through the endpoint tables and the registered queue RAM read.
// Reset clears all endpoint tables and the output valid flag at once; the queue
// RAM is not cleared and needs no clearing pass, so words are taken right away.
// ----------------------------------------------------------------------------
// notification_mailbox_queues_core
// Bank of mailbox endpoints, each with a circular queue of stamped
// notifications held in a shared RAM, behind a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module notification_mailbox_queues_core
    import nmq_pkg::*;
#(
    parameter int ENDPOINTS   = ENDPOINTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: endpoint_index[2:0], source_value[34:3], zero pad.
    input  wire logic [39:0] s_axis_tdata,
    // Fields from bit 0: cmd[1:0].
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: status[2:0], endpoint_out[5:3], note_source[37:6],
    // note_sequence[69:38], pending[70], active_total[74:71], zero pad.
    output logic [79:0]      m_axis_tdata
);

    localparam int RAM_DEPTH = ENDPOINTS * QUEUE_DEPTH;
    localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    logic              s_accept;
    logic              out_valid_reg;
    result_t           res_reg;
    result_t           res_next;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [63:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [63:0]       ram_rdata;
    logic [31:0]       note_source;
    logic [31:0]       note_sequence;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    nmq_ctrl #(
        .ENDPOINTS   (ENDPOINTS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (s_accept),
        .cmd            (s_axis_tuser),
        .endpoint_index (s_axis_tdata[2:0]),
        .source_value   (s_axis_tdata[34:3]),
        .res            (res_next),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr)
    );

    nmq_ram #(
        .WIDTH (64),
        .DEPTH (RAM_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            res_reg <= res_next;
        end
    end

    assign note_source   = res_reg.note_valid ? ram_rdata[31:0]  : 32'd0;
    assign note_sequence = res_reg.note_valid ? ram_rdata[63:32] : 32'd0;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, res_reg.active_total, res_reg.pending, note_sequence,
                            note_source, res_reg.endpoint_out, res_reg.status};

    `NMQ_ASSERT_IMPL(a_note_only_on_ok, out_valid_reg && res_reg.note_valid,
                     res_reg.status == ST_OK, "note returned with failing status")
    `NMQ_ASSERT_NEXT(a_result_follows_accept, s_accept, out_valid_reg,
                     "accepted word produced no result")
    `NMQ_ASSERT_IMPL(a_nofree_means_all_active, s_accept && res_next.status == ST_NOFREE,
                     res_next.active_total == 4'(ENDPOINTS),
                     "no free endpoint reported while endpoints are free")

endmodule

`default_nettype wire
